/* rtl/core/deq_pkg.sv */
// Shared types, constants and helper functions for the double-ended queue.
package deq_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VW    = 32;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_REAR  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_REAR   = 3'd3,
        KIND_READ_ALL   = 3'd4
    } deq_kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } deq_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_OUT,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } deq_state_t;

    typedef struct packed {
        logic        wr_front;
        logic        wr_rear;
        logic        rd_front;
        logic        rd_rear;
        logic        rd_idx;
        logic        idx_clr;
        logic        out_load;
        logic        out_use_mem;
        deq_status_t out_status;
        logic        out_last;
    } deq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic idx_last;
        logic out_free;
    } deq_flags_t;

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
        return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
    endfunction

endpackage

/* rtl/core/double_ended_queue_core.sv */
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Each beat on the input stream carries one request: the kind in tuser and the
// value to push in tdata. Each beat on the output stream carries one result:
// the status in tuser, the popped or read-out value in tdata, and tlast on the
// final result of a request. The queue holds up to 32 entries in a ring buffer.
// A push loads its result into the output register as it is accepted. A pop
// reads the ring memory first and then loads the output register. A read-out
// gives one result per stored entry, each set by the memory read port
// followed by the output register load. Requests are handled one at
// a time; a new request is taken once the previous one has loaded its final
// result and the output register is free or drains in the same cycle.
// Kinds five to seven are consumed and give no result.
// Reset empties the queue and clears the output valid; the entries themselves
// are not cleared. When the receiver stalls, the result holds in the output
// register and the block stops taking requests until it is drained.
module double_ended_queue_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic signed [31:0] s_axis_tdata,  // [31:0] value
    input  logic [2:0]         s_axis_tuser,  // [2:0] kind
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic signed [31:0] m_axis_tdata,  // [31:0] data
    output logic [1:0]         m_axis_tuser,  // [1:0] status
    output logic               m_axis_tlast
);

    deq_pkg::deq_cmd_t   cmd;
    deq_pkg::deq_flags_t flags;

    deq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .flags    (flags),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    deq_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_value   (s_axis_tdata),
        .out_ready  (m_axis_tready),
        .flags      (flags),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

/* rtl/core/deq_ctrl.sv */
// Controller state machine that sequences queue operations and result beats.
module deq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          in_kind,
    input  deq_pkg::deq_flags_t flags,
    output logic                in_ready,
    output deq_pkg::deq_cmd_t   cmd
);

    deq_pkg::deq_state_t state_reg;
    deq_pkg::deq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.out_status = deq_pkg::STAT_OK;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                in_ready = flags.out_free;
                if (in_valid && flags.out_free)
                begin
                    case (deq_pkg::deq_kind_t'(in_kind))
                        deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            if (flags.full)
                            begin
                                cmd.out_status = deq_pkg::STAT_FULL;
                            end
                            else if (in_kind == deq_pkg::KIND_PUSH_FRONT)
                            begin
                                cmd.wr_front = 1'b1;
                            end
                            else
                            begin
                                cmd.wr_rear = 1'b1;
                            end
                        end
                        deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR:
                        begin
                            if (flags.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_front = (in_kind == deq_pkg::KIND_POP_FRONT);
                                cmd.rd_rear  = (in_kind == deq_pkg::KIND_POP_REAR);
                                state_next   = deq_pkg::ST_POP_OUT;
                            end
                        end
                        deq_pkg::KIND_READ_ALL:
                        begin
                            if (flags.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.idx_clr = 1'b1;
                                state_next  = deq_pkg::ST_DUMP_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            deq_pkg::ST_POP_OUT:
            begin
                if (flags.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_use_mem = 1'b1;
                    cmd.out_last    = 1'b1;
                    state_next      = deq_pkg::ST_IDLE;
                end
            end
            deq_pkg::ST_DUMP_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = deq_pkg::ST_DUMP_OUT;
            end
            deq_pkg::ST_DUMP_OUT:
            begin
                if (flags.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_use_mem = 1'b1;
                    cmd.out_last    = flags.idx_last;
                    state_next      = flags.idx_last ? deq_pkg::ST_IDLE
                                                     : deq_pkg::ST_DUMP_RD;
                end
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/deq_dp.sv */
// Datapath with ring storage, front pointer, fill count and output register.
module deq_dp
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  deq_pkg::deq_cmd_t         cmd,
    input  logic signed [deq_pkg::VW-1:0] in_value,
    input  logic                      out_ready,
    output deq_pkg::deq_flags_t       flags,
    output logic                      out_valid,
    output logic [1:0]                out_status,
    output logic signed [deq_pkg::VW-1:0] out_data,
    output logic                      out_last
);

    logic [deq_pkg::VW-1:0] mem [deq_pkg::DEPTH];
    logic [deq_pkg::VW-1:0] rd_data_reg;

    logic [deq_pkg::AW-1:0] front_reg;
    logic [deq_pkg::AW-1:0] front_next;
    logic [deq_pkg::CW-1:0] count_reg;
    logic [deq_pkg::CW-1:0] count_next;
    logic [deq_pkg::CW-1:0] idx_reg;
    logic [deq_pkg::CW-1:0] idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [1:0]             out_status_reg;
    logic [deq_pkg::VW-1:0] out_data_reg;
    logic                   out_last_reg;

    logic                   wr_en;
    logic [deq_pkg::AW-1:0] wr_addr;
    logic                   rd_en;
    logic [deq_pkg::AW-1:0] rd_addr;

    always_comb
    begin
        wr_en      = cmd.wr_front || cmd.wr_rear;
        wr_addr    = cmd.wr_front ? deq_pkg::slot_dec(front_reg)
                                  : deq_pkg::slot_add(front_reg, count_reg);
        rd_en      = cmd.rd_front || cmd.rd_rear || cmd.rd_idx;
        rd_addr    = front_reg;
        if (cmd.rd_rear)
        begin
            rd_addr = deq_pkg::slot_add(front_reg, count_reg - deq_pkg::CW'(1));
        end
        else if (cmd.rd_idx)
        begin
            rd_addr = deq_pkg::slot_add(front_reg, idx_reg);
        end

        front_next = front_reg;
        count_next = count_reg;
        if (cmd.wr_front)
        begin
            front_next = deq_pkg::slot_dec(front_reg);
        end
        else if (cmd.rd_front)
        begin
            front_next = deq_pkg::slot_inc(front_reg);
        end
        if (wr_en)
        begin
            count_next = count_reg + deq_pkg::CW'(1);
        end
        else if (cmd.rd_front || cmd.rd_rear)
        begin
            count_next = count_reg - deq_pkg::CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_idx)
        begin
            idx_next = idx_reg + deq_pkg::CW'(1);
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_data_reg   <= cmd.out_use_mem ? rd_data_reg : '0;
            out_last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign flags.empty    = (count_reg == '0);
    assign flags.full     = (count_reg >= deq_pkg::CW'(deq_pkg::DEPTH));
    assign flags.idx_last = (idx_reg == count_reg);
    assign flags.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;

endmodule

/* rtl/core/deq_checker.sv */
// Port-level checker for the double-ended queue and its bind to the top level.
module deq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("Input beat taken while the output beat is stalled.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output beat dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("Output beat changed while stalled.");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != deq_pkg::STAT_OK |-> m_axis_tlast)
        else $error("Error result is not the final beat.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != deq_pkg::STAT_OK |-> m_axis_tdata == '0)
        else $error("Error result carries nonzero data.");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
